// File: design/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// No dependencies; imported by every module of the block.
package mbps_pkg;

    localparam int MAX_PATTERN = 8;
    localparam int POS_W       = 32;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 3'd0,
        REG_SKIP_MASK      = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_SEARCH_OFFSET  = 3'd3,
        REG_SEARCH_LIMIT   = 3'd4,
        REG_SEARCH_UPWARD  = 3'd5,
        REG_REPORT_ALL     = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [8*MAX_PATTERN-1:0] pattern_bytes;
        logic [MAX_PATTERN-1:0]   skip_mask;
        logic [LEN_W-1:0]         pattern_length;
        logic [POS_W-1:0]         search_offset;
        logic [POS_W-1:0]         search_limit;
        logic                     search_upward;
        logic                     report_all;
    } t_cfg;

endpackage

// File: design/masked_byte_pattern_search.sv
// Top level of the masked byte pattern search: config registers, input
// register, per-image scan state and result register. Uses mbps_pkg,
// mbps_match and mbps_window.
//
//  Channel   Direction  Handshake                   Content
//  s_axis    in         s_axis_tvalid/tready        image byte, tlast = end of image
//  m_axis    out        m_axis_tvalid/tready        hit position, tuser = found,
//                                                   tlast = last result of search
//  cfg       in         i_cfg_valid/o_cfg_ready     register index and value
//
// One byte per cycle while the result register is not stalled; each byte passes
// the input register and then the result register around the window compare.
// Reset clears the registers, the scan state and both pipeline stages.
// A stalled result register holds the scan stage; the input register still
// takes one byte while the result waits. cfg is always ready.
module masked_byte_pattern_search import mbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [POS_W-1:0]      m_axis_tdata,   // [31:0] match_position
    output logic                  m_axis_tuser,   // [0] found
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_last;

    logic [8*MAX_PATTERN-1:0] r_recent;
    logic [POS_W-1:0]         r_byte_pos;
    logic [POS_W-1:0]         r_best_pos;
    logic                     r_have_hit;
    logic                     r_search_done;

    logic                     r_out_valid;
    logic [POS_W-1:0]         r_out_pos;
    logic                     r_out_found;
    logic                     r_out_final;

    logic                     w_out_free;
    logic                     w_fire;
    logic [IDX_W-1:0]         w_len_m1;
    logic [8*MAX_PATTERN-1:0] n_recent;
    logic [POS_W-1:0]         w_start;
    logic                     w_pos_ok;
    logic                     w_in_window;
    logic                     w_match;
    logic                     w_hit;

    logic                     n_res_valid;
    logic [POS_W-1:0]         n_res_pos;
    logic                     n_res_found;
    logic                     n_res_final;
    logic [POS_W-1:0]         n_best_pos;
    logic                     n_have_hit;
    logic                     n_search_done;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes  <= '0;
            r_cfg.skip_mask      <= '0;
            r_cfg.pattern_length <= LEN_W'(1);
            r_cfg.search_offset  <= '0;
            r_cfg.search_limit   <= '0;
            r_cfg.search_upward  <= 1'b0;
            r_cfg.report_all     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_BYTES:  r_cfg.pattern_bytes  <= i_cfg_data[8*MAX_PATTERN-1:0];
                REG_SKIP_MASK:      r_cfg.skip_mask      <= i_cfg_data[MAX_PATTERN-1:0];
                REG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[LEN_W-1:0];
                REG_SEARCH_OFFSET:  r_cfg.search_offset  <= i_cfg_data[POS_W-1:0];
                REG_SEARCH_LIMIT:   r_cfg.search_limit   <= i_cfg_data[POS_W-1:0];
                REG_SEARCH_UPWARD:  r_cfg.search_upward  <= i_cfg_data[0];
                REG_REPORT_ALL:     r_cfg.report_all     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // ---------------- scan stage ----------------
    // length 0 counts as 1, anything above the maximum as the maximum
    always_comb begin
        if (r_cfg.pattern_length == '0) begin
            w_len_m1 = '0;
        end else if (r_cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
            w_len_m1 = IDX_W'(MAX_PATTERN - 1);
        end else begin
            w_len_m1 = IDX_W'(r_cfg.pattern_length - LEN_W'(1));
        end
    end

    assign n_recent = {r_recent[8*MAX_PATTERN-9:0], r_in_byte};
    assign w_pos_ok = (r_byte_pos >= POS_W'(w_len_m1));
    assign w_start  = r_byte_pos - POS_W'(w_len_m1);

    mbps_match u_match (
        .i_cfg    (r_cfg),
        .i_window (n_recent),
        .i_len_m1 (w_len_m1),
        .o_match  (w_match)
    );

    mbps_window u_window (
        .i_cfg       (r_cfg),
        .i_start     (w_start),
        .o_in_window (w_in_window)
    );

    assign w_hit = w_pos_ok && w_in_window && w_match;

    always_comb begin
        n_res_valid   = 1'b0;
        n_res_pos     = '0;
        n_res_found   = 1'b0;
        n_res_final   = 1'b0;
        n_best_pos    = r_best_pos;
        n_have_hit    = r_have_hit;
        n_search_done = r_search_done;

        if (w_hit && !r_search_done) begin
            priority if (r_cfg.report_all) begin
                n_res_valid = 1'b1;
                n_res_pos   = w_start;
                n_res_found = 1'b1;
                n_res_final = r_in_last;
            end else if (!r_cfg.search_upward) begin
                n_res_valid   = 1'b1;
                n_res_pos     = w_start;
                n_res_found   = 1'b1;
                n_res_final   = 1'b1;
                n_search_done = 1'b1;
            end else begin
                // ascending arrival, so the latest hit is the highest
                n_best_pos = w_start;
                n_have_hit = 1'b1;
            end
        end

        // closing result unless the search already gave its last one
        if (r_in_last && !n_res_valid && !r_search_done) begin
            n_res_valid = 1'b1;
            n_res_final = 1'b1;
            if (!r_cfg.report_all && r_cfg.search_upward && n_have_hit) begin
                n_res_pos   = n_best_pos;
                n_res_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent      <= '0;
            r_byte_pos    <= '0;
            r_best_pos    <= '0;
            r_have_hit    <= 1'b0;
            r_search_done <= 1'b0;
        end else if (w_fire) begin
            if (r_in_last) begin
                r_recent      <= '0;
                r_byte_pos    <= '0;
                r_best_pos    <= '0;
                r_have_hit    <= 1'b0;
                r_search_done <= 1'b0;
            end else begin
                r_recent      <= n_recent;
                r_byte_pos    <= r_byte_pos + POS_W'(1);
                r_best_pos    <= n_best_pos;
                r_have_hit    <= n_have_hit;
                r_search_done <= n_search_done;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= n_res_valid;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && n_res_valid) begin
            r_out_pos   <= n_res_pos;
            r_out_found <= n_res_found;
            r_out_final <= n_res_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pos;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tlast  = r_out_final;

    // ---------------- checks ----------------
    a_miss_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("miss result without final flag");

    a_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata == '0))
        else $error("miss result with non-zero position");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input held off without a stalled result");

    a_image_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_last |=> (r_byte_pos == '0) && !r_search_done && !r_have_hit)
        else $error("scan state not cleared after end of image");

endmodule

// File: design/mbps_match.sv
// Masked comparison of the newest pattern_length bytes against the pattern.
// Depends on mbps_pkg.
module mbps_match import mbps_pkg::*; (
    input  t_cfg                     i_cfg,
    input  logic [8*MAX_PATTERN-1:0] i_window,   // newest byte in bits 7..0
    input  logic [IDX_W-1:0]         i_len_m1,
    output logic                     o_match
);

    always_comb begin
        logic [IDX_W-1:0] j;
        logic [7:0]       have;
        logic [7:0]       want;
        o_match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            // pattern byte i lines up with the byte received len-1-i steps ago
            j    = i_len_m1 - IDX_W'(i);
            have = i_window[{j, 3'b000} +: 8];
            want = i_cfg.pattern_bytes[8*i +: 8];
            if ((IDX_W'(i) <= i_len_m1) && !i_cfg.skip_mask[i] && (want != have)) begin
                o_match = 1'b0;
            end
        end
    end

endmodule

// File: design/mbps_window.sv
// Candidate window test for one start position, both search directions.
// Depends on mbps_pkg.
module mbps_window import mbps_pkg::*; (
    input  t_cfg             i_cfg,
    input  logic [POS_W-1:0] i_start,
    output logic             o_in_window
);

    logic [POS_W-1:0] w_fwd_dist;
    logic [POS_W-1:0] w_up_dist;
    logic             w_lim_zero;

    assign w_fwd_dist = i_start - i_cfg.search_offset;
    assign w_up_dist  = i_cfg.search_offset - i_start;
    assign w_lim_zero = (i_cfg.search_limit == '0);

    always_comb begin
        if (!i_cfg.search_upward) begin
            o_in_window = (i_start >= i_cfg.search_offset) &&
                          (w_lim_zero || (w_fwd_dist < i_cfg.search_limit));
        end else if (w_lim_zero) begin
            // open downward window stops at position 1
            o_in_window = (i_start <= i_cfg.search_offset) && (i_start != '0);
        end else begin
            o_in_window = (i_start <= i_cfg.search_offset) &&
                          (w_up_dist < i_cfg.search_limit);
        end
    end

endmodule
